// ===== hdl/first_fit_partition_allocator_unit_macros.svh =====
// assertion macros shared by the allocator rtl
// no dependencies; included by the modules that carry assertions
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FFPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// next-cycle implication, checked outside reset
`define FFPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

// ===== hdl/ffpa_pkg.sv =====
// shared types, constants and codes of the first-fit partition allocator
// no dependencies; imported by ffpa_ctrl and the allocator top
package ffpa_pkg;

    // table geometry
    localparam int SLOTS      = 8;
    localparam int ADDR_BITS  = 24;
    localparam int SLOT_IDX_W = $clog2(SLOTS);

    // fixed field widths
    localparam int SIZE_W     = 10;
    localparam int SLOT_W     = 3;
    localparam int IN_ADDR_W  = 24;
    localparam int OUT_ADDR_W = 24;
    localparam int STATUS_W   = 2;
    localparam int KB_SHIFT   = 10;

    // stream word layout
    localparam int IN_SLOT_LO   = 0;
    localparam int IN_ADDR_LO   = IN_SLOT_LO + SLOT_W;
    localparam int IN_SIZE_LO   = IN_ADDR_LO + IN_ADDR_W;
    localparam int IN_USED_W    = IN_SIZE_LO + SIZE_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_USED_W   = OUT_ADDR_W + SLOT_W;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_USED_W;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LOADED    = 2'd2;

    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [SIZE_W-1:0]     t_size;
    typedef logic [SLOT_IDX_W-1:0] t_idx;

    // one incoming word, unpacked
    typedef struct packed {
        logic                 op;
        logic [SLOT_W-1:0]    slot;
        logic [IN_ADDR_W-1:0] start_address;
        t_size                size_kb;
    } t_item;

    // one result word
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OUT_ADDR_W-1:0] granted_address;
        logic [SLOT_W-1:0]     granted_slot;
    } t_result;

    // one slot of the partition table
    typedef struct packed {
        t_addr start;
        t_size size;
    } t_entry;

endpackage

// ===== hdl/ffpa_ram.sv =====
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ffpa_ctrl.sv =====
// allocator sequencer: loads slots and runs the first-fit scan over the table ram
// depends on ffpa_pkg, ffpa_ram and the assertion macro header
`include "first_fit_partition_allocator_unit_macros.svh"

module ffpa_ctrl import ffpa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_item   i_in_item,
    output logic    o_in_ready,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    localparam t_idx LAST_IDX = SLOT_IDX_W'(SLOTS - 1);

    t_state             r_state, n_state;
    t_idx               r_idx, n_idx;
    t_size              r_req, n_req;
    t_result            r_res, n_res;
    logic [SLOTS-1:0]   r_valid, n_valid;

    logic               ram_we;
    t_idx               ram_waddr;
    t_entry             ram_wdata;
    logic               ram_re;
    t_idx               ram_raddr;
    t_entry             ram_rdata;

    logic               in_acc;
    t_size              eff_size;
    logic               fit;
    t_addr              adv_start;

    // partition table: start address and size of each slot
    ffpa_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_acc = i_in_valid && o_in_ready;

    // slot under test; a never-loaded slot reads as empty
    assign eff_size  = r_valid[r_idx] ? ram_rdata.size : '0;
    assign fit       = (eff_size != '0) && (eff_size >= r_req);
    assign adv_start = ram_rdata.start + ADDR_BITS'({r_req, {KB_SHIFT{1'b0}}});

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_req     = r_req;
        n_res     = r_res;
        n_valid   = r_valid;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req = i_in_item.size_kb;
                    n_idx = '0;
                    if (i_in_item.op == OP_LOAD) begin
                        // out-of-range slot leaves the table alone
                        if (int'(i_in_item.slot) < SLOTS) begin
                            ram_we                = 1'b1;
                            ram_waddr             = SLOT_IDX_W'(i_in_item.slot);
                            ram_wdata.start       = ADDR_BITS'(i_in_item.start_address);
                            ram_wdata.size        = i_in_item.size_kb;
                            n_valid[ram_waddr]    = 1'b1;
                        end
                        n_res   = '{status: ST_LOADED, granted_address: '0, granted_slot: '0};
                        n_state = S_DONE;
                    end else if (i_in_item.size_kb == '0) begin
                        n_res   = '{status: ST_NO_SPACE, granted_address: '0, granted_slot: '0};
                        n_state = S_DONE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (fit) begin
                    // carve the request off the front of this slot
                    ram_we          = 1'b1;
                    ram_waddr       = r_idx;
                    ram_wdata.start = adv_start;
                    ram_wdata.size  = eff_size - r_req;
                    n_res.status          = ST_ALLOCATED;
                    n_res.granted_address = OUT_ADDR_W'(ram_rdata.start);
                    n_res.granted_slot    = SLOT_W'(r_idx);
                    n_state = S_DONE;
                end else if (r_idx == LAST_IDX) begin
                    n_res   = '{status: ST_NO_SPACE, granted_address: '0, granted_slot: '0};
                    n_state = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx + 1'b1;
                    n_idx     = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_req <= n_req;
        r_res <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    // a table write never collides with a table read
    `FFPA_ASSERT_IMP(a_no_rw_overlap, i_clk, i_rst_n, ram_we, !ram_re)
    // a write during the scan always closes the item
    `FFPA_ASSERT_NXT(a_scan_write_ends, i_clk, i_rst_n, ram_we && (r_state == S_SCAN),
        r_state == S_DONE)
    // an accepted word leaves the idle state
    `FFPA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, in_acc, r_state != S_IDLE)
    // a granted slot was loaded at some point
    `FFPA_ASSERT_IMP(a_grant_loaded, i_clk, i_rst_n, (r_state == S_SCAN) && fit, r_valid[r_idx])

endmodule

// ===== hdl/first_fit_partition_allocator_unit.sv =====
// First-fit partition allocator. A load word (tuser 0) writes one slot of the free-partition
// table with a byte start address and a size in KB; a size of zero empties the slot. An
// allocate word (tuser 1) walks the slots from 0 up and takes the first one whose size is at
// least the request, answering with its start address and slot and then moving that start up
// by request*1024 bytes. A zero request or no fitting slot answers no space. Exactly one result
// word leaves per input word. A load or a zero request goes straight to the done state; an
// allocation scans the slots in the scan state, the table ram reading one slot per cycle,
// until a slot fits or the last slot is read. A new input word is taken only in the idle
// state, once the result has passed on to the output register, and a stalled output holds
// the block in the done state. Slot flags cleared by reset make every slot empty, so no
// clearing pass is needed. The result sits in an output register, so a new word is taken
// while the last result still waits.
// depends on ffpa_pkg and ffpa_ctrl
module first_fit_partition_allocator_unit import ffpa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // slot[2:0], start_address[26:3], size_kb[36:27], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op[0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // granted_address[23:0], granted_slot[26:24], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]    m_axis_tuser
);

    t_item   in_item;
    logic    res_valid;
    logic    res_ready;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    // unpack the input word
    assign in_item.op            = s_axis_tuser;
    assign in_item.slot          = s_axis_tdata[IN_SLOT_LO +: SLOT_W];
    assign in_item.start_address = s_axis_tdata[IN_ADDR_LO +: IN_ADDR_W];
    assign in_item.size_kb       = s_axis_tdata[IN_SIZE_LO +: SIZE_W];

    ffpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_item   (in_item),
        .o_in_ready  (s_axis_tready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // output register
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.granted_slot, r_out.granted_address};
    assign m_axis_tuser  = r_out.status;

endmodule

// ===== dv/first_fit_partition_allocator_unit_tb.sv =====
// self-checking testbench of the first-fit partition allocator: stream words in, one reply per word
// a behavioral table model predicts every reply; depends on ffpa_pkg and the allocator rtl
module first_fit_partition_allocator_unit_tb;
    import ffpa_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // slot[2:0], start_address[26:3], size_kb[36:27], zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // op[0]
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // granted_address[23:0], granted_slot[26:24], zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // status[1:0]
    logic [STATUS_W-1:0]    m_axis_tuser;

    // free-partition table as the testbench sees it
    t_addr     part_start [SLOTS];
    t_size     part_size  [SLOTS];
    t_result   expected_replies [$];
    int        mismatch_count;
    bit        src_idle_en;
    bit        sink_idle_en;
    int        sink_hold;

    first_fit_partition_allocator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // apply one word to the table and return the reply it must produce
    function automatic t_result carve_partition(input t_item w);
        t_result r;
        t_addr   base;
        r.status          = ST_NO_SPACE;
        r.granted_address = '0;
        r.granted_slot    = '0;
        if (w.op == OP_LOAD) begin
            if (int'(w.slot) < SLOTS) begin
                part_start[w.slot] = t_addr'(w.start_address);
                part_size[w.slot]  = w.size_kb;
            end
            r.status = ST_LOADED;
            return r;
        end
        if (w.size_kb == 0)
            return r;
        // first slot large enough wins
        for (int i = 0; i < SLOTS; i++) begin
            if (part_size[i] != 0 && part_size[i] >= w.size_kb) begin
                base          = part_start[i];
                part_start[i] = base + (t_addr'(w.size_kb) << KB_SHIFT);
                part_size[i]  = part_size[i] - w.size_kb;
                r.status          = ST_ALLOCATED;
                r.granted_address = OUT_ADDR_W'(base);
                r.granted_slot    = SLOT_W'(i);
                return r;
            end
        end
        return r;
    endfunction

    // offer one word; returns at the edge that accepts it with tvalid still high
    task automatic offer_word(input logic op, input logic [SLOT_W-1:0] slot,
                              input logic [IN_ADDR_W-1:0] addr, input t_size size);
        t_item w;
        int    gap;
        w.op            = op;
        w.slot          = slot;
        w.start_address = addr;
        w.size_kb       = size;
        @(negedge i_clk);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = IN_TDATA_W'({size, addr, slot});
        do @(posedge i_clk); while (!s_axis_tready);
        expected_replies.insert(expected_replies.size(), carve_partition(w));
    endtask

    // sender goes quiet until every reply is back, then idles before returning
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (SLOTS + 4) @(posedge i_clk);
    endtask

    function automatic logic [IN_ADDR_W-1:0] pick_address();
        if ($urandom_range(0, 7) == 0)
            return IN_ADDR_W'(24'hFFFFFF - $urandom_range(0, 4095));
        return IN_ADDR_W'($urandom());
    endfunction

    // reply checker
    task automatic compare_field(input string name, input int unsigned exp_v,
                                 input int unsigned act_v);
        if (exp_v != act_v) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected 0x%0h actual 0x%0h", name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected reply word: status %0d tdata 0x%0h",
                             m_axis_tuser, m_axis_tdata);
            end else begin
                exp_r = expected_replies.pop_front();
                compare_field("status", exp_r.status, m_axis_tuser);
                compare_field("granted_address", exp_r.granted_address,
                              m_axis_tdata[OUT_ADDR_W-1:0]);
                compare_field("granted_slot", exp_r.granted_slot,
                              m_axis_tdata[OUT_ADDR_W +: SLOT_W]);
                compare_field("tdata pad", 0, m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W]);
            end
        end
    end

    // receiver: long holds on request, random stall bursts, otherwise ready
    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                m_axis_tready = 1'b0;
            end else if (sink_hold > 0) begin
                m_axis_tready = 1'b0;
                sink_hold--;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // allocations on an empty table
    task automatic test_empty_table();
        offer_word(OP_ALLOC, 3'd0, 24'h000000, 10'd1);
        offer_word(OP_ALLOC, 3'd7, 24'hFFFFFF, 10'd0);
        offer_word(OP_ALLOC, 3'd5, 24'hAAAAAA, 10'd1023);
        wait_drained();
    endtask

    // loads at the field extremes, an empty load, exact fits and first-fit order
    task automatic test_load_and_fit();
        offer_word(OP_LOAD,  3'd0, 24'h000000, 10'd0);
        offer_word(OP_ALLOC, 3'd0, 24'h000000, 10'd1);
        offer_word(OP_LOAD,  3'd7, 24'hFFFFFF, 10'd1023);
        offer_word(OP_LOAD,  3'd0, 24'h000000, 10'd1);
        offer_word(OP_LOAD,  3'd3, 24'hABCDE0, 10'd0);
        offer_word(OP_ALLOC, 3'd0, 24'h000000, 10'd1);
        // second request lands in slot 7 and its start wraps past the top
        offer_word(OP_ALLOC, 3'd0, 24'h000000, 10'd1);
        offer_word(OP_ALLOC, 3'd0, 24'h000000, 10'd1022);
        offer_word(OP_ALLOC, 3'd0, 24'h000000, 10'd1);
        wait_drained();
    endtask

    // smaller slots earlier in the table are skipped, starts wrap on advance
    task automatic test_address_wrap();
        offer_word(OP_LOAD,  3'd2, 24'hFFFC00, 10'd512);
        offer_word(OP_LOAD,  3'd5, 24'h123456, 10'd1023);
        offer_word(OP_ALLOC, 3'd6, 24'h555555, 10'd1023);
        offer_word(OP_ALLOC, 3'd1, 24'h000001, 10'd512);
        offer_word(OP_LOAD,  3'd2, 24'h800000, 10'd3);
        offer_word(OP_ALLOC, 3'd2, 24'h000000, 10'd0);
        offer_word(OP_ALLOC, 3'd4, 24'h000000, 10'd2);
        offer_word(OP_ALLOC, 3'd4, 24'h000000, 10'd1);
        wait_drained();
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        bit keep_idle;
        keep_idle   = src_idle_en;
        src_idle_en = 1'b0;
        sink_hold   = 200;
        for (int i = 0; i < 12; i++) begin
            if (i % 3 == 0)
                offer_word(OP_LOAD, SLOT_W'(i), pick_address(), t_size'($urandom_range(1, 1023)));
            else
                offer_word(OP_ALLOC, 3'd0, 24'h000000, t_size'($urandom_range(1, 200)));
        end
        src_idle_en = keep_idle;
        wait_drained();
    endtask

    // random loads and requests, biased toward fits and exact fits
    task automatic test_random_traffic(input int count);
        int                  pick;
        logic [SLOT_W-1:0]   slot;
        t_size               size;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            slot = SLOT_W'($urandom());
            if (pick < 35) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    size = '0;
                else if (pick == 1)
                    size = 10'd1023;
                else
                    size = t_size'($urandom_range(1, 1023));
                offer_word(OP_LOAD, slot, pick_address(), size);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    size = '0;
                else if (pick < 25)
                    size = (part_size[slot] != 0) ? part_size[slot] : t_size'(1);
                else if (pick < 70)
                    size = t_size'($urandom_range(1, 64));
                else
                    size = t_size'($urandom_range(1, 1023));
                offer_word(OP_ALLOC, slot, IN_ADDR_W'($urandom()), size);
            end
        end
        wait_drained();
    endtask

    // run limit
    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    // test sequence
    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_LOAD;
        mismatch_count = 0;
        src_idle_en    = 1'b1;
        sink_idle_en   = 1'b1;
        sink_hold      = 0;
        for (int i = 0; i < SLOTS; i++) begin
            part_start[i] = '0;
            part_size[i]  = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_load_and_fit();
        test_address_wrap();
        test_backpressure();
        test_random_traffic(700);
        test_backpressure();
        test_random_traffic(700);
        // closing stretch with no idling on either side
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_random_traffic(300);

        mismatch_count += expected_replies.size();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
